FILE: hw/rtl/asl_pkg.sv
// Shared types and constants for the asymmetric speed slew limiter.
package asl_pkg;

    localparam int SPEED_W = 16;
    localparam int TIME_W  = 16;
    localparam int RATE_W  = 12;
    localparam int LIM_W   = 15;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 3;
    localparam int WORK_W  = SPEED_W + 1;
    localparam int DIST_W  = 16;
    localparam int PROD_W  = RATE_W + TIME_W;
    localparam int FRAC_SH = 10;
    localparam int NUM_W   = DIST_W + FRAC_SH;
    localparam int REM_W   = RATE_W;
    localparam int CNT_W   = 4;

    localparam logic [IDX_W-1:0] REG_ACCEL_FWD = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_REV = 3'd1;
    localparam logic [IDX_W-1:0] REG_DECEL_FWD = 3'd2;
    localparam logic [IDX_W-1:0] REG_DECEL_REV = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED_LIM = 3'd4;

    localparam logic [RATE_W-1:0] RATE_RESET  = 12'd256;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd2560;

    typedef struct packed {
        logic load;
        logic setup;
        logic to_zero;
        logic mul;
        logic take_tgt;
        logic step;
        logic div_start;
        logic div_step;
        logic div_last;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic sign_diff;
        logic d_zero;
        logic a_zero;
        logic reach;
    } t_sts;

endpackage

FILE: hw/rtl/asymmetric_speed_slew_limiter_core.sv
// Top level of the asymmetric speed slew limiter.
// One word is taken at a time; s_axis_tready is high only while the core is idle. The
// result comes from a single ramp phase when the speed keeps its sign or the ramp toward
// zero does not reach zero; when the speed starts at zero and the target is negative, a
// second ramp phase toward the target follows; and when a nonzero speed reaches zero
// inside the interval, the leftover time comes from a restoring divider, one quotient bit
// per cycle, followed by a second ramp phase. The result
// waits in an output register while the next word is accepted and ramped; a result still
// waiting there holds the next one back until the sink takes it.
module asymmetric_speed_slew_limiter_core import asl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,  // [15:0] target_speed, [31:16] elapsed_time
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata   // [15:0] new_speed
);

    t_cmd cmd;
    t_sts sts;

    asl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    asl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_new_speed (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/asl_datapath.sv
// Datapath: config registers, ramp arithmetic, divider and clamp.
module asl_datapath import asl_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  logic [SPEED_W+TIME_W-1:0] i_word,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic [SPEED_W-1:0]        o_new_speed
);

    logic [RATE_W-1:0]        r_accel_fwd, r_accel_rev, r_decel_fwd, r_decel_rev;
    logic [LIM_W-1:0]         r_limit;
    logic signed [SPEED_W-1:0] r_cur;
    logic signed [SPEED_W-1:0] r_tgt;
    logic [TIME_W-1:0]        r_t;
    logic signed [WORK_W-1:0] r_v;
    logic signed [WORK_W-1:0] r_rt;
    logic [RATE_W-1:0]        r_a;
    logic [DIST_W-1:0]        r_d;
    logic                     r_up;
    logic [PROD_W-1:0]        r_prod;
    logic [REM_W-1:0]         r_rem;
    logic [TIME_W-1:0]        r_qn;
    logic [SPEED_W-1:0]       r_out;

    logic signed [WORK_W-1:0] n_rt;
    logic [WORK_W-1:0]        mag_rt, mag_v;
    logic signed [WORK_W:0]   diff;
    logic [WORK_W:0]          mag_diff;
    logic [RATE_W-1:0]        n_a;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         dist_sh;
    logic [REM_W:0]           trial;
    logic                     qbit;
    logic [REM_W-1:0]         n_rem;
    logic [TIME_W-1:0]        n_qn;
    logic [DIST_W-1:0]        step_amt;
    logic signed [WORK_W-1:0] stepped;
    logic signed [WORK_W-1:0] lim_pos, lim_neg, clamped;

    always_comb begin
        n_rt   = i_cmd.to_zero ? '0 : WORK_W'(r_tgt);
        mag_rt = n_rt[WORK_W-1] ? WORK_W'(-n_rt) : WORK_W'(n_rt);
        mag_v  = r_v[WORK_W-1] ? WORK_W'(-r_v) : WORK_W'(r_v);
        diff   = (WORK_W+1)'(n_rt) - (WORK_W+1)'(r_v);
        mag_diff = diff[WORK_W] ? (WORK_W+1)'(-diff) : (WORK_W+1)'(diff);
        if (mag_rt > mag_v) begin
            n_a = n_rt[WORK_W-1] ? r_accel_rev : r_accel_fwd;
        end else begin
            n_a = n_rt[WORK_W-1] ? r_decel_rev : r_decel_fwd;
        end
    end

    always_comb begin
        dist_sh = {r_d, {FRAC_SH{1'b0}}};
        num     = dist_sh + NUM_W'(r_a) - NUM_W'(1);
        trial   = {r_rem, r_qn[TIME_W-1]};
        qbit    = trial >= (REM_W+1)'(r_a);
        n_rem   = qbit ? REM_W'(trial - (REM_W+1)'(r_a)) : REM_W'(trial);
        n_qn    = {r_qn[TIME_W-2:0], qbit};
    end

    always_comb begin
        step_amt = r_prod[FRAC_SH +: DIST_W];
        stepped  = r_up ? r_v + WORK_W'({1'b0, step_amt})
                        : r_v - WORK_W'({1'b0, step_amt});
        lim_pos  = WORK_W'({2'b00, r_limit});
        lim_neg  = -lim_pos;
        if (r_v > lim_pos) begin
            clamped = lim_pos;
        end else if (r_v < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = r_v;
        end
    end

    assign o_sts.sign_diff = i_word[SPEED_W-1] ^ r_cur[SPEED_W-1];
    assign o_sts.d_zero    = r_d == '0;
    assign o_sts.a_zero    = r_a == '0;
    assign o_sts.reach     = r_prod >= PROD_W'(dist_sh);
    assign o_new_speed     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fwd <= RATE_RESET;
            r_accel_rev <= RATE_RESET;
            r_decel_fwd <= RATE_RESET;
            r_decel_rev <= RATE_RESET;
            r_limit     <= LIMIT_RESET;
            r_cur       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_ACCEL_FWD: r_accel_fwd <= i_cfg_wdata[RATE_W-1:0];
                    REG_ACCEL_REV: r_accel_rev <= i_cfg_wdata[RATE_W-1:0];
                    REG_DECEL_FWD: r_decel_fwd <= i_cfg_wdata[RATE_W-1:0];
                    REG_DECEL_REV: r_decel_rev <= i_cfg_wdata[RATE_W-1:0];
                    REG_SPEED_LIM: r_limit     <= i_cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_cur <= clamped[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt <= i_word[SPEED_W-1:0];
            r_t   <= i_word[SPEED_W +: TIME_W];
            r_v   <= WORK_W'(r_cur);
        end
        if (i_cmd.setup) begin
            r_rt <= n_rt;
            r_a  <= n_a;
            r_d  <= mag_diff[DIST_W-1:0];
            r_up <= r_v < n_rt;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_a) * PROD_W'(r_t);
        end
        if (i_cmd.take_tgt) begin
            r_v <= r_rt;
        end
        if (i_cmd.step) begin
            r_v <= stepped;
        end
        if (i_cmd.div_start) begin
            r_rem <= REM_W'(num[NUM_W-1:TIME_W]);
            r_qn  <= num[TIME_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_qn  <= n_qn;
        end
        if (i_cmd.div_last) begin
            r_t <= r_t - n_qn;
        end
        if (i_cmd.finish) begin
            r_out <= clamped[SPEED_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/asl_ctrl.sv
// Controller: sequences load, ramp phases, divide and result handoff.
module asl_ctrl import asl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_zero_ph, n_zero_ph;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_zero_ph   = r_zero_ph;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.to_zero = r_zero_ph;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_zero_ph  = i_sts.sign_diff;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_MULT;
            end
            S_MULT: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.d_zero) begin
                    o_cmd.take_tgt = 1'b1;
                    n_state   = r_zero_ph ? S_SETUP : S_FINISH;
                    n_zero_ph = 1'b0;
                end else if (i_sts.a_zero) begin
                    n_state = S_FINISH;
                end else if (i_sts.reach) begin
                    o_cmd.take_tgt = 1'b1;
                    if (r_zero_ph) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == '1) begin
                    o_cmd.div_last = 1'b1;
                    n_zero_ph = 1'b0;
                    n_state   = S_SETUP;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zero_ph   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_zero_ph   <= n_zero_ph;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: tb/asymmetric_speed_slew_limiter_core_tb.sv
// Self-checking testbench for the asymmetric speed slew limiter core.
`timescale 1ns / 100ps

module asymmetric_speed_slew_limiter_core_tb import asl_pkg::*;;

    localparam int RUN_LIMIT_NS    = 10_000_000;
    localparam int IDLE_SETTLE     = 30;
    localparam int DRAIN_LIMIT     = 10_000;
    localparam int RAND_PHASES     = 16;
    localparam int ITEMS_PER_PHASE = 100;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;  // [15:0] target_speed, [31:16] elapsed_time
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;        // [15:0] new_speed

    logic [RATE_W-1:0]  rate_af   = RATE_RESET;
    logic [RATE_W-1:0]  rate_ar   = RATE_RESET;
    logic [RATE_W-1:0]  rate_df   = RATE_RESET;
    logic [RATE_W-1:0]  rate_dr   = RATE_RESET;
    logic [LIM_W-1:0]   spd_limit = LIMIT_RESET;
    int                 speed_now = 0;

    logic [15:0]        expected_speeds[$];
    logic [15:0]        speed_want;
    int                 mismatch_cnt = 0;
    bit                 src_steady   = 1'b0;

    asymmetric_speed_slew_limiter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [RATE_W-1:0] pick_rate(int v, int goal);
        int mv;
        int mg;
        mv = (v < 0) ? -v : v;
        mg = (goal < 0) ? -goal : goal;
        if (mg > mv) begin
            return (goal >= 0) ? rate_af : rate_ar;
        end
        return (goal >= 0) ? rate_df : rate_dr;
    endfunction

    function automatic int ramp_toward(int v, int goal, int unsigned t,
                                       output bit hit, output int unsigned left);
        longint rate;
        longint span;
        longint prod;
        longint need;
        rate = pick_rate(v, goal);
        span = goal - v;
        if (span < 0) begin
            span = -span;
        end
        prod = rate * longint'(t);
        hit  = 1'b0;
        left = 0;
        if (span == 0) begin
            hit  = 1'b1;
            left = t;
            return goal;
        end
        if (rate == 0) begin
            return v;
        end
        if (prod >= span * 1024) begin
            need = (span * 1024 + rate - 1) / rate;
            hit  = 1'b1;
            left = t - int'(need);
            return goal;
        end
        if (v < goal) begin
            return v + int'(prod >>> 10);
        end
        return v - int'(prod >>> 10);
    endfunction

    function automatic logic [15:0] next_speed(logic [15:0] tgt_bits, logic [15:0] dt);
        int          tgt;
        int          v;
        int          lim;
        bit          hit;
        int unsigned left;
        tgt = $signed(tgt_bits);
        v   = speed_now;
        lim = int'(spd_limit);
        if ((tgt >= 0) != (v >= 0)) begin
            v = ramp_toward(v, 0, int'(dt), hit, left);
            if (hit) begin
                v = ramp_toward(v, tgt, left, hit, left);
            end
        end else begin
            v = ramp_toward(v, tgt, int'(dt), hit, left);
        end
        if (v > lim) begin
            v = lim;
        end
        if (v < -lim) begin
            v = -lim;
        end
        speed_now = v;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_target();
        int lim;
        int v;
        lim = int'(spd_limit);
        v   = speed_now;
        case ($urandom_range(0, 9))
            0, 1, 2: v = v + int'($urandom_range(0, 1024)) - 512;
            3, 4: begin
                if (v >= 0) begin
                    v = -int'($urandom_range(0, lim)) - 1;
                end else begin
                    v = int'($urandom_range(0, lim));
                end
            end
            5:       v = 0;
            6, 7:    v = int'($urandom_range(0, 2 * lim)) - lim;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 255));
            6, 7:             return 16'($urandom_range(0, 4095));
            8:                return 16'($urandom_range(0, 65535));
            default:          return 16'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_tick(input logic [15:0] tgt, input logic [15:0] dt);
        int gap;
        int r;
        s_axis_tdata  <= {dt, tgt};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_speeds.push_back(next_speed(tgt, dt));
        r = $urandom_range(0, 99);
        if (src_steady || r < 55) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_ACCEL_FWD: rate_af   = val[RATE_W-1:0];
            REG_ACCEL_REV: rate_ar   = val[RATE_W-1:0];
            REG_DECEL_FWD: rate_df   = val[RATE_W-1:0];
            REG_DECEL_REV: rate_dr   = val[RATE_W-1:0];
            REG_SPEED_LIM: spd_limit = val[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] af, input logic [CFG_W-1:0] ar,
                               input logic [CFG_W-1:0] df, input logic [CFG_W-1:0] dr,
                               input logic [CFG_W-1:0] lim);
        write_reg(REG_ACCEL_FWD, af);
        write_reg(REG_ACCEL_REV, ar);
        write_reg(REG_DECEL_FWD, df);
        write_reg(REG_DECEL_REV, dr);
        write_reg(REG_SPEED_LIM, lim);
        cfg_close();
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_speeds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(16'sd3000, 16'd16384);
        send_tick(16'sd2560, 16'd0);
        send_tick(-16'sd100, 16'd512);
    endtask

    task automatic test_field_extremes();
        drain_results();
        load_config(15'h7FFF, 15'h0FFF, 15'h7FFF, 15'h0FFF, 15'h7FFF);
        send_tick(16'sd32767, 16'hFFFF);
        send_tick(16'sh8000, 16'hFFFF);
        send_tick(16'sd0, 16'd0);
        send_tick(16'sh8000, 16'd0);
        send_tick(16'sd0, 16'hFFFF);
    endtask

    task automatic test_rate_selection();
        drain_results();
        load_config(15'd64, 15'd128, 15'd512, 15'd1024, 15'h7FFF);
        send_tick(16'sd8000, 16'd1024);
        send_tick(16'sd20, 16'd1024);
        send_tick(-16'sd8000, 16'd1024);
        send_tick(-16'sd50, 16'd1024);
        send_tick(-16'sd4000, 16'd100);
    endtask

    task automatic test_zero_crossing();
        drain_results();
        load_config(15'd300, 15'd300, 15'd2000, 15'd300, 15'h7FFF);
        send_tick(16'sd1000, 16'hFFFF);
        send_tick(-16'sd1000, 16'd300);
        send_tick(-16'sd1000, 16'd1024);
        send_tick(16'sd1000, 16'd2);
    endtask

    task automatic test_zero_rate();
        drain_results();
        load_config(15'd0, 15'd0, 15'd0, 15'd0, 15'h7FFF);
        send_tick(16'sd1500, 16'd4096);
        send_tick(-16'sd20000, 16'd4096);
        send_tick(16'sd0, 16'hFFFF);
        send_tick(speed_now[15:0], 16'd500);
    endtask

    task automatic test_limit_change();
        drain_results();
        load_config(15'h0FFF, 15'h0FFF, 15'h0FFF, 15'h0FFF, 15'h7FFF);
        send_tick(16'sd20000, 16'hFFFF);
        drain_results();
        write_reg(REG_SPEED_LIM, 15'd1000);
        write_reg(REG_SPARE_LO, 15'h7FFF);
        cfg_close();
        send_tick(16'sd20000, 16'd0);
        drain_results();
        write_reg(REG_SPEED_LIM, 15'd0);
        write_reg(REG_SPARE_HI, 15'h5555);
        cfg_close();
        send_tick(-16'sd5, 16'd10);
        send_tick(16'sd32767, 16'hFFFF);
    endtask

    function automatic logic [CFG_W-1:0] random_rate();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 15'h0FFF;
            2:       return CFG_W'($urandom_range(1, 64));
            default: return CFG_W'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [CFG_W-1:0] lim;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            case ($urandom_range(0, 2))
                0:       lim = 15'h7FFF;
                1:       lim = CFG_W'($urandom_range(1, 512));
                default: lim = CFG_W'($urandom_range(0, 32767));
            endcase
            if (ph == 0) begin
                load_config(15'h0FFF, 15'h0FFF, 15'h0FFF, 15'h0FFF, 15'h7FFF);
            end else if (ph == 1) begin
                load_config('0, '0, '0, '0, '0);
            end else begin
                write_reg(REG_ACCEL_FWD, random_rate());
                write_reg(REG_ACCEL_REV, random_rate());
                write_reg(REG_DECEL_FWD, random_rate());
                write_reg(REG_DECEL_REV, random_rate());
                write_reg(REG_SPEED_LIM, lim);
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                              CFG_W'($urandom_range(0, 32767)));
                end
                cfg_close();
            end
            src_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_tick(pick_target(), pick_elapsed());
            end
        end
        src_steady = 1'b0;
    endtask

    initial begin : sink_pace
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        m_axis_tready <= 1'b1;
                        hold = $urandom_range(0, 7);
                    end
                    5, 6: begin
                        m_axis_tready <= 1'b0;
                        hold = $urandom_range(0, 2);
                    end
                    7: begin
                        m_axis_tready <= 1'b0;
                        hold = $urandom_range(10, 40);
                    end
                    8: begin
                        m_axis_tready <= 1'b1;
                        hold = $urandom_range(50, 200);
                    end
                    default: begin
                        m_axis_tready <= 1'b1;
                        hold = 0;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_speeds.size() == 0) begin
                $display("%0t: new_speed expected none, actual %0d",
                         $time, $signed(m_axis_tdata));
                mismatch_cnt++;
            end else begin
                speed_want = expected_speeds.pop_front();
                if (m_axis_tdata !== speed_want) begin
                    $display("%0t: new_speed expected %0d, actual %0d",
                             $time, $signed(speed_want), $signed(m_axis_tdata));
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_rate_selection();
        test_zero_crossing();
        test_zero_rate();
        test_limit_change();
        test_random_traffic();
        drain_results();
        if (expected_speeds.size() != 0) begin
            $display("%0t: new_speed expected %0d more words, actual none",
                     $time, expected_speeds.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
